### rtl/core/nwhd_pkg.sv
package nwhd_pkg;

   // Window geometry
   localparam int RADIUS    = 5;
   localparam int WIN_DEPTH = 2 * RADIUS + 1;
   localparam int WIN_W     = $clog2(WIN_DEPTH);
   localparam int FILL_W    = $clog2(WIN_DEPTH + 1);
   localparam int D_W       = $clog2(RADIUS + 1);

   // Arithmetic widths
   localparam int TEMP_W = 32;
   localparam int DIFF_W = 16;
   localparam int FRAC_W = 16;
   localparam int ACC_W  = TEMP_W + 1 + $clog2(2 * RADIUS);
   localparam int PROD_W = ACC_W + DIFF_W + 1;
   localparam int SH_W   = PROD_W - FRAC_W;
   localparam int RES_W  = SH_W + 2;
   localparam int STEP_W = $clog2(SH_W + 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_LOAD,
      ST_SUM,
      ST_MUL,
      ST_DSTART,
      ST_DIV,
      ST_FINISH
   } state_type;

   typedef struct packed {
      logic shift;
      logic set_flush;
      logic set_mid;
      logic load;
      logic sum_step;
      logic mul;
      logic div_start;
      logic emit;
   } cmd_type;

   typedef struct packed {
      logic fill_ready;
      logic last_mode;
      logic sum_end;
      logic div_done;
      logic out_free;
      logic d_zero;
   } status_type;

endpackage

### rtl/core/nwhd_divider.sv
module nwhd_divider (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start_i,
   input  logic [nwhd_pkg::SH_W-1:0]   dividend_i,
   input  logic [nwhd_pkg::WIN_W-1:0]  divisor_i,
   output logic [nwhd_pkg::SH_W-1:0]   quotient_o,
   output logic                        done_o
);
   import nwhd_pkg::*;

   logic [SH_W-1:0]   quo_ff;
   logic [WIN_W-1:0]  rem_ff;
   logic [WIN_W-1:0]  dvs_ff;
   logic [STEP_W-1:0] steps_ff;
   logic              busy_ff;
   logic              done_ff;

   logic [WIN_W:0]    rem_sh;
   logic [WIN_W:0]    rem_sub;
   logic              fits;
   logic [WIN_W-1:0]  rem_in;

   // One restoring step: shift in the next dividend bit, subtract if it fits
   always_comb begin
      rem_sh  = {rem_ff, quo_ff[SH_W-1]};
      fits    = rem_sh >= {1'b0, dvs_ff};
      rem_sub = rem_sh - {1'b0, dvs_ff};
      rem_in  = fits ? rem_sub[WIN_W-1:0] : rem_sh[WIN_W-1:0];
   end

   // Sequence control
   always_ff @(posedge clock) begin
      if (reset) begin
         steps_ff <= '0;
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
      end else if (start_i) begin
         steps_ff <= STEP_W'(SH_W);
         busy_ff  <= 1'b1;
         done_ff  <= 1'b0;
      end else if (busy_ff) begin
         steps_ff <= steps_ff - 1'b1;
         if (steps_ff == STEP_W'(1)) begin
            busy_ff <= 1'b0;
            done_ff <= 1'b1;
         end
      end
   end

   // Quotient and remainder shift
   always_ff @(posedge clock) begin
      if (start_i) begin
         quo_ff <= dividend_i;
         rem_ff <= '0;
         dvs_ff <= divisor_i;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[SH_W-2:0], fits};
         rem_ff <= rem_in;
      end
   end

   assign quotient_o = quo_ff;
   assign done_o     = done_ff;

   a_start_busy: assert property (@(posedge clock) disable iff (reset)
      start_i |=> busy_ff && !done_ff)
      else $error("divider did not start");

endmodule

### rtl/core/nwhd_ctrl.sv
module nwhd_ctrl (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  nwhd_pkg::status_type   status_i,
   output nwhd_pkg::cmd_type      cmd_o
);
   import nwhd_pkg::*;

   state_type state_ff;
   state_type state_in;

   // State register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Next state and commands
   always_comb begin
      state_in  = state_ff;
      cmd_o     = '0;
      req_stall = 1'b1;
      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               cmd_o.shift = 1'b1;
               state_in    = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status_i.last_mode) begin
               cmd_o.set_flush = 1'b1;
               state_in        = ST_LOAD;
            end else if (status_i.fill_ready) begin
               cmd_o.set_mid = 1'b1;
               state_in      = ST_LOAD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_LOAD: begin
            cmd_o.load = 1'b1;
            state_in   = ST_SUM;
         end
         ST_SUM: begin
            cmd_o.sum_step = 1'b1;
            if (status_i.sum_end) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL: begin
            cmd_o.mul = 1'b1;
            state_in  = ST_DSTART;
         end
         ST_DSTART: begin
            cmd_o.div_start = 1'b1;
            state_in        = ST_DIV;
         end
         ST_DIV: begin
            if (status_i.div_done) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            if (status_i.out_free) begin
               cmd_o.emit = 1'b1;
               if (status_i.last_mode && !status_i.d_zero) begin
                  state_in = ST_LOAD;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   a_accept_then_busy: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall && state_ff == ST_DECIDE)
      else $error("item accepted without moving to decide");

endmodule

### rtl/core/nwhd_datapath.sv
module nwhd_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  logic signed [nwhd_pkg::TEMP_W-1:0] req_temperature_in,
   input  logic                               req_last_sample,
   input  logic                               csr_write,
   input  logic [nwhd_pkg::DIFF_W-1:0]        csr_data,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [nwhd_pkg::TEMP_W-1:0] rsp_temperature_out,
   output logic                               rsp_last_result,
   input  nwhd_pkg::cmd_type                  cmd_i,
   output nwhd_pkg::status_type               status_o
);
   import nwhd_pkg::*;

   // Sample window, newest at index 0
   logic signed [TEMP_W-1:0] win_ff [WIN_DEPTH];

   logic [FILL_W-1:0]        fill_ff;
   logic                     last_mode_ff;
   logic [D_W-1:0]           d_ff;
   logic [WIN_W-1:0]         i_ff;
   logic [WIN_W-1:0]         count_ff;
   logic [DIFF_W-1:0]        diff_ff;
   logic signed [TEMP_W-1:0] centre_ff;
   logic signed [ACC_W-1:0]  acc_ff;
   logic signed [PROD_W-1:0] prod_ff;
   logic                     rsp_valid_ff;
   logic signed [TEMP_W-1:0] temperature_out_ff;
   logic                     last_result_ff;

   logic [FILL_W-1:0]        fill_m1;
   logic [D_W-1:0]           flush_d;
   logic [FILL_W-1:0]        older_raw;
   logic [FILL_W-1:0]        older;
   logic [FILL_W-1:0]        count_w;
   logic [WIN_W-1:0]         rd_addr;
   logic signed [TEMP_W-1:0] rd_data;
   logic signed [ACC_W-1:0]  diff_val;
   logic signed [PROD_W-1:0] shifted_full;
   logic [SH_W-1:0]          shifted;
   logic                     neg;
   logic [SH_W-1:0]          mag;
   logic [SH_W-1:0]          quo;
   logic                     div_done;
   logic signed [RES_W-1:0]  q_signed;
   logic signed [RES_W-1:0]  res;
   logic signed [TEMP_W-1:0] res_sat;
   logic                     out_free;

   // Neighbor span for the current distance, clipped at both ends
   always_comb begin
      fill_m1   = fill_ff - 1'b1;
      flush_d   = (fill_m1 > FILL_W'(RADIUS)) ? D_W'(RADIUS) : fill_m1[D_W-1:0];
      older_raw = fill_m1 - FILL_W'(d_ff);
      older     = (older_raw > FILL_W'(RADIUS)) ? FILL_W'(RADIUS) : older_raw;
      count_w   = older + FILL_W'(d_ff);
   end

   // Single window read port: center on load, neighbors while summing
   always_comb begin
      rd_addr  = cmd_i.load ? WIN_W'(d_ff) : i_ff;
      rd_data  = win_ff[rd_addr];
      diff_val = ACC_W'(rd_data) - ACC_W'(centre_ff);
   end

   // Floor shift of the product, split into sign and magnitude
   always_comb begin
      shifted_full = prod_ff >>> FRAC_W;
      shifted      = shifted_full[SH_W-1:0];
      neg          = shifted[SH_W-1];
      mag          = neg ? (~shifted + 1'b1) : shifted;
   end

   nwhd_divider u_div (
      .clock      (clock),
      .reset      (reset),
      .start_i    (cmd_i.div_start),
      .dividend_i (mag),
      .divisor_i  (count_ff),
      .quotient_o (quo),
      .done_o     (div_done)
   );

   // Signed quotient, add center, saturate
   always_comb begin
      if (count_ff == '0) begin
         q_signed = '0;
      end else if (neg) begin
         q_signed = -signed'(RES_W'(quo));
      end else begin
         q_signed = signed'(RES_W'(quo));
      end
      res = RES_W'(centre_ff) + q_signed;
      if (res[RES_W-1:TEMP_W-1] == '0 || res[RES_W-1:TEMP_W-1] == '1) begin
         res_sat = res[TEMP_W-1:0];
      end else if (res[RES_W-1]) begin
         res_sat = {1'b1, {(TEMP_W-1){1'b0}}};
      end else begin
         res_sat = {1'b0, {(TEMP_W-1){1'b1}}};
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         fill_ff      <= '0;
         last_mode_ff <= 1'b0;
         d_ff         <= '0;
         i_ff         <= '0;
         diff_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_write) begin
            diff_ff <= csr_data;
         end
         if (cmd_i.shift) begin
            last_mode_ff <= req_last_sample;
            if (fill_ff != FILL_W'(WIN_DEPTH)) begin
               fill_ff <= fill_ff + 1'b1;
            end
         end
         if (cmd_i.set_flush) begin
            d_ff <= flush_d;
         end
         if (cmd_i.set_mid) begin
            d_ff <= D_W'(RADIUS);
         end
         if (cmd_i.load) begin
            i_ff <= '0;
         end
         if (cmd_i.sum_step) begin
            i_ff <= i_ff + 1'b1;
         end
         // Hand off the result; in flush walk toward the newest sample
         if (cmd_i.emit) begin
            rsp_valid_ff <= 1'b1;
            if (last_mode_ff) begin
               if (d_ff == '0) begin
                  fill_ff <= '0;
               end else begin
                  d_ff <= d_ff - 1'b1;
               end
            end
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Datapath registers
   always_ff @(posedge clock) begin
      if (cmd_i.shift) begin
         win_ff[0] <= req_temperature_in;
         for (int k = 1; k < WIN_DEPTH; k++) begin
            win_ff[k] <= win_ff[k-1];
         end
      end
      if (cmd_i.load) begin
         centre_ff <= rd_data;
         count_ff  <= count_w[WIN_W-1:0];
         acc_ff    <= '0;
      end
      if (cmd_i.sum_step && i_ff != WIN_W'(d_ff)) begin
         acc_ff <= acc_ff + diff_val;
      end
      if (cmd_i.mul) begin
         prod_ff <= acc_ff * signed'({1'b0, diff_ff});
      end
      if (cmd_i.emit) begin
         temperature_out_ff <= res_sat;
         last_result_ff     <= last_mode_ff && (d_ff == '0);
      end
   end

   always_comb begin
      status_o.fill_ready = fill_ff >= FILL_W'(RADIUS + 1);
      status_o.last_mode  = last_mode_ff;
      status_o.sum_end    = i_ff == count_ff;
      status_o.div_done   = div_done;
      status_o.out_free   = out_free;
      status_o.d_zero     = d_ff == '0;
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_temperature_out = temperature_out_ff;
   assign rsp_last_result     = last_result_ff;

   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd_i.emit |-> (!rsp_valid_ff || !rsp_stall))
      else $error("result overwrote a stalled item");

   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      fill_ff <= FILL_W'(WIN_DEPTH))
      else $error("fill level beyond window depth");

   a_flush_clears: assert property (@(posedge clock) disable iff (reset)
      (cmd_i.emit && last_mode_ff && d_ff == '0) |=> fill_ff == '0)
      else $error("stream end did not clear fill level");

endmodule

### rtl/core/neighbor_window_heat_diffusion.sv
// Windowed heat diffusion over a stream of Q16.16 particle temperatures.
// Request channel (req_valid / req_stall): one temperature per item in
// particle order, req_last_sample marks the end of a stream.
// Response channel (rsp_valid / rsp_stall): one diffused temperature per
// particle, oldest first; rsp_last_result marks the final particle.
// Config channel (csr_valid / csr_ready / csr_data): diffusivity, Q0.16.
// Write it only while the block is idle; csr_ready is always high.
// An item yields a result once RADIUS later samples are in; the last item
// flushes up to RADIUS+1 results, one after another.
// Each result runs these steps (count = neighbors used, at most
// 2*RADIUS): load, count + 1 window taps, multiply, divider start, a
// 38-step restoring divider and a wait for its done flag, then emit.
// The divider takes most of the time. Accept and decide come before
// the first result of an item; req_stall stays high until the last
// result of that item (if any) is placed in the output register.
// A stalled result waits in the output register; the block can take the
// next item meanwhile and holds its own next result until the slot frees.
// Reset clears the window fill level and sets diffusivity to zero.
module neighbor_window_heat_diffusion (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [nwhd_pkg::TEMP_W-1:0] req_temperature_in,
   input  logic                               req_last_sample,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic signed [nwhd_pkg::TEMP_W-1:0] rsp_temperature_out,
   output logic                               rsp_last_result,
   input  logic                               csr_valid,
   output logic                               csr_ready,
   input  logic [nwhd_pkg::DIFF_W-1:0]        csr_data
);
   import nwhd_pkg::*;

   cmd_type    cmd;
   status_type status;
   logic       csr_write;

   // Config writes are always taken
   assign csr_ready = 1'b1;
   assign csr_write = csr_valid && csr_ready;

   nwhd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status_i  (status),
      .cmd_o     (cmd)
   );

   nwhd_datapath u_datapath (
      .clock               (clock),
      .reset               (reset),
      .req_temperature_in  (req_temperature_in),
      .req_last_sample     (req_last_sample),
      .csr_write           (csr_write),
      .csr_data            (csr_data),
      .rsp_valid           (rsp_valid),
      .rsp_stall           (rsp_stall),
      .rsp_temperature_out (rsp_temperature_out),
      .rsp_last_result     (rsp_last_result),
      .cmd_i               (cmd),
      .status_o            (status)
   );

endmodule
